// ----- rtl/core/mdaau_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the multidimensional array address unit.
// No dependencies; every other file of the block but mdaau_ram imports this package.
package mdaau_pkg;

    // Fixed field widths of the request and result transfers.
    localparam int REQ_W    = 2;
    localparam int ID_FW    = 4;
    localparam int BASE_W   = 31;
    localparam int SIZE_W   = 16;
    localparam int CNT_W    = 4;
    localparam int DIDX_W   = 3;
    localparam int WORD_W   = 32;
    localparam int POS_W    = 4;
    localparam int DESC_W   = BASE_W + SIZE_W + CNT_W;
    localparam int BOUNDS_W = 2 * WORD_W;

    // Request type codes.
    localparam logic [REQ_W-1:0] REQ_HEADER = 2'd0;
    localparam logic [REQ_W-1:0] REQ_BOUNDS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXT,
        ST_MUL,
        ST_ACC,
        ST_SIZE,
        ST_BASE
    } mdaau_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_header;
        logic wr_bounds;
        logic start_query;
        logic calc_ext;
        logic mul_ext;
        logic acc;
        logic mul_size;
        logic load_out;
    } mdaau_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic id_ok;
        logic dim_ok;
        logic pos_zero;
        logic last_index;
        logic out_free;
    } mdaau_status_t;

endpackage

// ----- rtl/core/mdaau_in_if.sv -----
`timescale 1ns / 1ps
// Request channel of the array address unit: valid/ready and the request payload.
// Depends on mdaau_pkg for the field widths.
interface mdaau_in_if import mdaau_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [ID_FW-1:0]         array_id;
    logic [BASE_W-1:0]        base_address;
    logic [SIZE_W-1:0]        element_size;
    logic [CNT_W-1:0]         dim_count;
    logic [DIDX_W-1:0]        dim_index;
    logic signed [WORD_W-1:0] lower_bound;
    logic signed [WORD_W-1:0] upper_bound;
    logic signed [WORD_W-1:0] index_value;

    modport source (
        output valid, req_type, array_id, base_address, element_size, dim_count,
               dim_index, lower_bound, upper_bound, index_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, array_id, base_address, element_size, dim_count,
               dim_index, lower_bound, upper_bound, index_value,
        output ready
    );

endinterface

// ----- rtl/core/mdaau_out_if.sv -----
`timescale 1ns / 1ps
// Result channel of the array address unit: valid/ready and the address payload.
// Depends on mdaau_pkg for the field widths.
interface mdaau_out_if import mdaau_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] address;
    logic [ID_FW-1:0]         query_array;

    modport source (
        output valid, address, query_array,
        input  ready
    );

    modport sink (
        input  valid, address, query_array,
        output ready
    );

endinterface

// ----- rtl/core/multidim_array_address_unit_top.sv -----
`timescale 1ns / 1ps
// Top level of the multidimensional array address unit: controller plus datapath.
// Depends on mdaau_pkg, mdaau_in_if, mdaau_out_if, mdaau_ctrl and mdaau_dp.
//
// This unit computes element addresses for row-major arrays whose dimensions
// carry arbitrary signed lower and upper bounds. Header transfers record an
// array's base address, element size and dimension count; bounds transfers
// record the bounds of one dimension. Query transfers then deliver one
// subscript per dimension, first dimension first, and once the owner array's
// dimension count is reached the unit returns base + size * offset, where the
// offset is accumulated in Horner form and all arithmetic wraps modulo 2^32.
// The first subscript of a query names the owning array; later subscripts use
// that array whatever id they carry. Header and bounds transfers are written
// straight from idle. A subscript that does not complete a query passes
// through the registered read of the descriptor and bounds memories, the
// extent and difference step, the multiply and the accumulate. A final
// subscript adds the element size multiply and the base add, which waits
// until the result register is free. The steps are set by the single
// shared 32 by 32 multiplier and the registered memory reads. The result
// register lets a new request be taken while a finished address still waits
// to be collected. Descriptor memories are not cleared after reset; an array
// must be described before it is queried.
module multidim_array_address_unit_top import mdaau_pkg::*; #(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    mdaau_in_if.sink    request,
    mdaau_out_if.source result
);

    mdaau_cmd_t    cmd;
    mdaau_status_t status;

    // Sequencing of each transfer through the shared datapath.
    mdaau_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_type  (request.req_type),
        .req_ready (request.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Memories, multiplier, accumulator and the result register.
    mdaau_dp #(
        .MAX_ARRAYS (MAX_ARRAYS),
        .MAX_DIMS   (MAX_DIMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .array_id     (request.array_id),
        .base_address (request.base_address),
        .element_size (request.element_size),
        .dim_count    (request.dim_count),
        .dim_index    (request.dim_index),
        .lower_bound  (request.lower_bound),
        .upper_bound  (request.upper_bound),
        .index_value  (request.index_value),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .address      (result.address),
        .query_array  (result.query_array)
    );

endmodule

// ----- rtl/core/mdaau_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module mdaau_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                     wr_data,
    input  logic                                 rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mdaau_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the array address unit.
// Depends on mdaau_pkg for the state, command and status types.
module mdaau_ctrl import mdaau_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    output logic             req_ready,
    input  mdaau_status_t    status,
    output mdaau_cmd_t       cmd
);

    mdaau_state_t state_reg;
    mdaau_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    case (req_type)
                        REQ_HEADER:
                        begin
                            cmd.wr_header = status.id_ok;
                        end
                        REQ_BOUNDS:
                        begin
                            cmd.wr_bounds = status.id_ok && status.dim_ok;
                        end
                        REQ_QUERY:
                        begin
                            // A first subscript with an unknown id is dropped.
                            if (!status.pos_zero || status.id_ok)
                            begin
                                cmd.start_query = 1'b1;
                                state_next      = ST_EXT;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXT:
            begin
                cmd.calc_ext = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul_ext = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = status.last_index ? ST_SIZE : ST_IDLE;
            end
            ST_SIZE:
            begin
                cmd.mul_size = 1'b1;
                state_next   = ST_BASE;
            end
            ST_BASE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/mdaau_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the array address unit: descriptor memories, shared multiplier,
// Horner accumulator and output register. Depends on mdaau_pkg and mdaau_ram.
module mdaau_dp import mdaau_pkg::*; #(
    parameter int MAX_ARRAYS = 16,
    parameter int MAX_DIMS   = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mdaau_cmd_t               cmd,
    output mdaau_status_t            status,
    input  logic [ID_FW-1:0]         array_id,
    input  logic [BASE_W-1:0]        base_address,
    input  logic [SIZE_W-1:0]        element_size,
    input  logic [CNT_W-1:0]         dim_count,
    input  logic [DIDX_W-1:0]        dim_index,
    input  logic signed [WORD_W-1:0] lower_bound,
    input  logic signed [WORD_W-1:0] upper_bound,
    input  logic signed [WORD_W-1:0] index_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] address,
    output logic [ID_FW-1:0]         query_array
);

    localparam int ID_W       = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int DIM_W      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int SLOT_W     = ID_W + DIM_W;
    localparam int SLOT_DEPTH = 1 << SLOT_W;

    logic [POS_W-1:0]  pos_reg;
    logic [WORD_W-1:0] partial_reg;
    logic [ID_FW-1:0]  owner_reg;
    logic [WORD_W-1:0] idx_reg;
    logic [WORD_W-1:0] extent_reg;
    logic [WORD_W-1:0] diff_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] addr_reg;
    logic [ID_FW-1:0]  qarr_reg;
    logic              out_valid_reg;

    logic [CNT_W-1:0]    dims_clamped;
    logic [ID_FW-1:0]    owner_sel;
    logic [POS_W-1:0]    pos_clamped;
    logic [POS_W-1:0]    pos_inc;
    logic [SLOT_W-1:0]   wr_slot;
    logic [SLOT_W-1:0]   rd_slot;
    logic [DESC_W-1:0]   desc_rd;
    logic [BOUNDS_W-1:0] bounds_rd;
    logic [BASE_W-1:0]   base_rd;
    logic [SIZE_W-1:0]   size_rd;
    logic [CNT_W-1:0]    dims_rd;
    logic [WORD_W-1:0]   lower_rd;
    logic [WORD_W-1:0]   upper_rd;
    logic [WORD_W-1:0]   mul_b;
    logic [WORD_W-1:0]   mul_full;

    // Header writes clamp the dimension count into the supported range.
    always_comb
    begin
        if (dim_count == '0)
        begin
            dims_clamped = CNT_W'(1);
        end
        else if (dim_count > CNT_W'(MAX_DIMS))
        begin
            dims_clamped = CNT_W'(MAX_DIMS);
        end
        else
        begin
            dims_clamped = dim_count;
        end
    end

    assign owner_sel   = (pos_reg == '0) ? array_id : owner_reg;
    assign pos_clamped = (pos_reg >= POS_W'(MAX_DIMS)) ? POS_W'(MAX_DIMS - 1) : pos_reg;
    assign pos_inc     = pos_reg + POS_W'(1);
    assign wr_slot     = {ID_W'(array_id), DIM_W'(dim_index)};
    assign rd_slot     = {ID_W'(owner_sel), DIM_W'(pos_clamped)};

    mdaau_ram #(
        .WIDTH (DESC_W),
        .DEPTH (MAX_ARRAYS)
    ) u_desc_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_header),
        .wr_addr (ID_W'(array_id)),
        .wr_data ({base_address, element_size, dims_clamped}),
        .rd_en   (cmd.start_query),
        .rd_addr (ID_W'(owner_sel)),
        .rd_data (desc_rd)
    );

    mdaau_ram #(
        .WIDTH (BOUNDS_W),
        .DEPTH (SLOT_DEPTH)
    ) u_bounds_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_bounds),
        .wr_addr (wr_slot),
        .wr_data ({$unsigned(upper_bound), $unsigned(lower_bound)}),
        .rd_en   (cmd.start_query),
        .rd_addr (rd_slot),
        .rd_data (bounds_rd)
    );

    assign base_rd  = desc_rd[DESC_W-1 -: BASE_W];
    assign size_rd  = desc_rd[CNT_W +: SIZE_W];
    assign dims_rd  = desc_rd[CNT_W-1:0];
    assign lower_rd = bounds_rd[WORD_W-1:0];
    assign upper_rd = bounds_rd[BOUNDS_W-1 -: WORD_W];

    // One multiplier serves both the extent step and the element size step.
    // Only the low word of the product is kept, as all arithmetic wraps.
    assign mul_b    = cmd.mul_size ? {{(WORD_W - SIZE_W){1'b0}}, size_rd} : extent_reg;
    assign mul_full = partial_reg * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            partial_reg   <= '0;
            owner_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start_query && (pos_reg == '0))
            begin
                owner_reg <= array_id;
            end
            if (cmd.acc)
            begin
                partial_reg <= prod_reg + diff_reg;
                pos_reg     <= status.last_index ? '0 : pos_inc;
            end
            else if (cmd.load_out)
            begin
                partial_reg <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            idx_reg <= $unsigned(index_value);
        end
        if (cmd.calc_ext)
        begin
            extent_reg <= upper_rd - lower_rd + WORD_W'(1);
            diff_reg   <= idx_reg - lower_rd;
        end
        if (cmd.mul_ext || cmd.mul_size)
        begin
            prod_reg <= mul_full;
        end
        if (cmd.load_out)
        begin
            addr_reg <= {{(WORD_W - BASE_W){1'b0}}, base_rd} + prod_reg;
            qarr_reg <= owner_reg;
        end
    end

    assign status.id_ok      = (9'(array_id) < 9'(MAX_ARRAYS));
    assign status.dim_ok     = (4'(dim_index) < 4'(MAX_DIMS));
    assign status.pos_zero   = (pos_reg == '0);
    assign status.last_index = (pos_inc >= dims_rd);
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign address     = $signed(addr_reg);
    assign query_array = qarr_reg;

endmodule

// ----- rtl/core/mdaau_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the array address unit, bound to the top level.
// Depends on mdaau_pkg and on multidim_array_address_unit_top for the bind.
module mdaau_checker import mdaau_pkg::*; #(
    parameter int MAX_ARRAYS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    input  logic                     req_ready,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [ID_FW-1:0]         req_array_id,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  logic signed [WORD_W-1:0] res_address,
    input  logic [ID_FW-1:0]         res_query_array
);

    logic req_fire;
    logic known_query;
    logic descr_fire;

    assign req_fire    = req_valid && req_ready;
    assign known_query = req_fire && (req_type == REQ_QUERY)
                         && (9'(req_array_id) < 9'(MAX_ARRAYS));
    assign descr_fire  = req_fire && ((req_type == REQ_HEADER) || (req_type == REQ_BOUNDS));

    // A result that is offered stays offered until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_address) && $stable(res_query_array))
        else $error("result payload changed while stalled");

    // A subscript for a known array occupies the unit in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        known_query |=> !req_ready)
        else $error("unit ready straight after a query subscript");

    // Descriptor transfers leave the unit ready in the next cycle and never produce a result.
    a_descr_quick: assert property (@(posedge clk) disable iff (!rst_n)
        descr_fire |=> req_ready && !$rose(res_valid))
        else $error("descriptor transfer stalled the unit or produced a result");

    // A new result only appears straight after the unit was busy.
    a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(!req_ready))
        else $error("result appeared without a query being processed");

endmodule

bind multidim_array_address_unit_top mdaau_checker #(
    .MAX_ARRAYS (MAX_ARRAYS)
) u_mdaau_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (request.valid),
    .req_ready       (request.ready),
    .req_type        (request.req_type),
    .req_array_id    (request.array_id),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_address     (result.address),
    .res_query_array (result.query_array)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the multidimensional array address unit.
// Depends on mdaau_pkg, mdaau_in_if, mdaau_out_if and multidim_array_address_unit_top.
module tb_top;
    import mdaau_pkg::*;

    localparam int NUM_ARRAYS  = 16;
    localparam int NUM_DIMS    = 8;
    localparam int IDLE_PCT    = 31;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 120;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    // The package has no name for the spare request code, so give it one here.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [ID_FW-1:0]  array_id;
        logic [BASE_W-1:0] base_address;
        logic [SIZE_W-1:0] element_size;
        logic [CNT_W-1:0]  dim_count;
        logic [DIDX_W-1:0] dim_index;
        logic [WORD_W-1:0] lower_bound;
        logic [WORD_W-1:0] upper_bound;
        logic [WORD_W-1:0] index_value;
    } addr_request_t;

    typedef struct packed {
        logic [WORD_W-1:0] address;
        logic [ID_FW-1:0]  query_array;
    } addr_result_t;

    logic clk;
    logic rst_n = 1'b0;

    mdaau_in_if  request_ch ();
    mdaau_out_if result_ch ();

    multidim_array_address_unit_top #(
        .MAX_ARRAYS (NUM_ARRAYS),
        .MAX_DIMS   (NUM_DIMS)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    // Everything the testbench drives on the two channels comes from these variables, so
    // every channel input of the block holds a known value from time zero.
    logic          drv_valid   = 1'b0;
    logic          sink_ready  = 1'b0;
    logic          req_taken   = 1'b0;
    addr_request_t cur_req     = '0;

    assign request_ch.valid        = drv_valid;
    assign request_ch.req_type     = cur_req.req_type;
    assign request_ch.array_id     = cur_req.array_id;
    assign request_ch.base_address = cur_req.base_address;
    assign request_ch.element_size = cur_req.element_size;
    assign request_ch.dim_count    = cur_req.dim_count;
    assign request_ch.dim_index    = cur_req.dim_index;
    assign request_ch.lower_bound  = cur_req.lower_bound;
    assign request_ch.upper_bound  = cur_req.upper_bound;
    assign request_ch.index_value  = cur_req.index_value;
    assign result_ch.ready         = sink_ready;

    addr_request_t queued_requests [$];
    addr_result_t  expected_addresses [$];

    int  error_count    = 0;
    int  items_queued   = 0;
    int  requests_taken = 0;
    int  idle_cycles    = 0;
    int  hold_left      = 0;
    bit  hold_done      = 1'b0;
    bit  steady         = 1'b0;

    // Address calculator state. There are two copies: copy 0 follows the
    // transfers the block has actually accepted and produces the expected
    // addresses, copy 1 runs ahead with the stimulus generator so that it knows
    // which array owns the query in progress and at which position it stands.
    logic [WORD_W-1:0] base_mem   [2][NUM_ARRAYS];
    logic [SIZE_W-1:0] esize_mem  [2][NUM_ARRAYS];
    logic [CNT_W-1:0]  ndims_mem  [2][NUM_ARRAYS];
    logic [WORD_W-1:0] lower_mem  [2][NUM_ARRAYS*NUM_DIMS];
    logic [WORD_W-1:0] upper_mem  [2][NUM_ARRAYS*NUM_DIMS];
    logic [POS_W-1:0]  sub_count  [2];
    logic [WORD_W-1:0] horner_acc [2];
    logic [ID_FW-1:0]  owner_id   [2];

    // The descriptor memories are not cleared by reset, so the generator keeps
    // track of what has been written and never lets a query read anything else.
    bit hdr_known [NUM_ARRAYS];
    bit bnd_known [NUM_ARRAYS*NUM_DIMS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Applies one request to one copy of the calculator state. Returns 1 when a
    // query completes, with the element address in addr_out. The offset is
    // built up Horner-fashion; every step wraps modulo 2^32.
    function automatic bit calc_element_address(input int cp, input addr_request_t rq,
                                                output addr_result_t addr_out);
        logic [CNT_W-1:0]  dims;
        logic [WORD_W-1:0] extent;
        int                slot;
        int                pos;
        calc_element_address = 1'b0;
        addr_out = '0;
        case (rq.req_type)
            REQ_HEADER:
            begin
                dims = rq.dim_count;
                if (dims == 0)
                    dims = 1;
                if (dims > NUM_DIMS)
                    dims = NUM_DIMS;
                base_mem[cp][rq.array_id]  = {1'b0, rq.base_address};
                esize_mem[cp][rq.array_id] = rq.element_size;
                ndims_mem[cp][rq.array_id] = dims;
            end
            REQ_BOUNDS:
            begin
                lower_mem[cp][rq.array_id*NUM_DIMS + rq.dim_index] = rq.lower_bound;
                upper_mem[cp][rq.array_id*NUM_DIMS + rq.dim_index] = rq.upper_bound;
            end
            REQ_QUERY:
            begin
                // The first subscript decides which array owns the query.
                if (sub_count[cp] == 0)
                    owner_id[cp] = rq.array_id;
                pos  = (sub_count[cp] >= NUM_DIMS) ? NUM_DIMS - 1 : sub_count[cp];
                slot = owner_id[cp]*NUM_DIMS + pos;
                extent = upper_mem[cp][slot] - lower_mem[cp][slot] + 1;
                horner_acc[cp] = horner_acc[cp] * extent
                                 + (rq.index_value - lower_mem[cp][slot]);
                sub_count[cp] = sub_count[cp] + 1;
                // The count is compared with the owner's current dimension
                // count, which a header may have lowered mid-query.
                if (sub_count[cp] >= ndims_mem[cp][owner_id[cp]])
                begin
                    addr_out.address = base_mem[cp][owner_id[cp]]
                                       + esize_mem[cp][owner_id[cp]] * horner_acc[cp];
                    addr_out.query_array = owner_id[cp];
                    sub_count[cp]  = '0;
                    horner_acc[cp] = '0;
                    calc_element_address = 1'b1;
                end
            end
            default: ;  // the spare request code changes nothing
        endcase
    endfunction

    // Fills every field with random bits; callers overwrite the fields in use.
    function automatic addr_request_t noise_request();
        addr_request_t rq;
        rq.req_type     = REQ_W'($urandom);
        rq.array_id     = ID_FW'($urandom);
        rq.base_address = BASE_W'($urandom);
        rq.element_size = SIZE_W'($urandom);
        rq.dim_count    = CNT_W'($urandom);
        rq.dim_index    = DIDX_W'($urandom);
        rq.lower_bound  = $urandom;
        rq.upper_bound  = $urandom;
        rq.index_value  = $urandom;
        return rq;
    endfunction

    task automatic push_request(input addr_request_t rq);
        addr_result_t unused;
        void'(calc_element_address(1, rq, unused));
        if (rq.req_type == REQ_HEADER)
            hdr_known[rq.array_id] = 1'b1;
        if (rq.req_type == REQ_BOUNDS)
            bnd_known[rq.array_id*NUM_DIMS + rq.dim_index] = 1'b1;
        queued_requests.push_back(rq);
        items_queued++;
    endtask

    task automatic push_header(input logic [ID_FW-1:0] id, input logic [BASE_W-1:0] base,
                               input logic [SIZE_W-1:0] esize, input logic [CNT_W-1:0] dims);
        addr_request_t rq;
        rq = noise_request();
        rq.req_type     = REQ_HEADER;
        rq.array_id     = id;
        rq.base_address = base;
        rq.element_size = esize;
        rq.dim_count    = dims;
        push_request(rq);
    endtask

    task automatic push_bounds(input logic [ID_FW-1:0] id, input logic [DIDX_W-1:0] dim,
                               input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi);
        addr_request_t rq;
        rq = noise_request();
        rq.req_type    = REQ_BOUNDS;
        rq.array_id    = id;
        rq.dim_index   = dim;
        rq.lower_bound = lo;
        rq.upper_bound = hi;
        push_request(rq);
    endtask

    // Queues one subscript. If the query would read a descriptor or a bound that
    // has never been written, a header or bounds transfer is queued first. With
    // use_given clear the subscript is mostly chosen inside the dimension's range.
    task automatic push_subscript(input logic [ID_FW-1:0] id, input bit use_given,
                                  input logic [WORD_W-1:0] given);
        logic [ID_FW-1:0]  owner;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] span;
        addr_request_t     rq;
        int                slot;
        if (sub_count[1] == 0)
        begin
            owner = id;
            if (!hdr_known[id])
                push_header(id, BASE_W'($urandom), SIZE_W'($urandom_range(1, 64)),
                            CNT_W'($urandom_range(1, 3)));
        end
        else
            owner = owner_id[1];
        slot = owner*NUM_DIMS + sub_count[1];
        if (!bnd_known[slot])
        begin
            lo = $urandom_range(0, 200) - 100;
            push_bounds(owner, DIDX_W'(sub_count[1]), lo, lo + $urandom_range(0, 9));
        end
        rq = noise_request();
        rq.req_type = REQ_QUERY;
        rq.array_id = id;
        span = upper_mem[1][slot] - lower_mem[1][slot];
        if (use_given)
            rq.index_value = given;
        else if (span < 1000 && $urandom_range(0, 99) < 85)
            rq.index_value = lower_mem[1][slot] + $urandom_range(0, span);
        else
            rq.index_value = $urandom;
        push_request(rq);
    endtask

    // Random traffic: mostly subscripts that walk queries to completion, with
    // headers and bounds mixed in (some of them landing on the array that owns
    // the query in progress) and a little of the spare request code as noise.
    task automatic queue_random(input int upto);
        addr_request_t     rq;
        logic [WORD_W-1:0] lo;
        int                pick;
        while (items_queued < upto)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                pick = $urandom_range(0, 99);
                push_header(ID_FW'($urandom),
                            BASE_W'($urandom),
                            ($urandom_range(0, 1) != 0) ? SIZE_W'($urandom_range(1, 65535))
                                                        : SIZE_W'($urandom_range(1, 64)),
                            (pick < 70) ? CNT_W'($urandom_range(1, 3)) :
                            (pick < 90) ? CNT_W'($urandom_range(4, 8)) : CNT_W'($urandom));
            end
            else if (pick < 18)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    lo = $urandom_range(0, 200) - 100;
                    push_bounds(ID_FW'($urandom), DIDX_W'($urandom), lo,
                                lo + $urandom_range(0, 9));
                end
                else
                    push_bounds(ID_FW'($urandom), DIDX_W'($urandom), $urandom, $urandom);
            end
            else if (pick < 22)
            begin
                rq = noise_request();
                rq.req_type = REQ_UNUSED;
                push_request(rq);
            end
            else if (sub_count[1] != 0 && $urandom_range(0, 99) < 70)
                push_subscript(owner_id[1], 1'b0, '0);
            else
                push_subscript(ID_FW'($urandom), 1'b0, '0);
        end
    endtask

    // Returns once everything queued has been accepted and every expected
    // address has been collected.
    task automatic wait_drained();
        while (queued_requests.size() != 0 || drv_valid || expected_addresses.size() != 0)
            @(negedge clk);
    endtask

    // Sender: a new request is presented only when the previous one has been
    // taken or none is on offer; valid never drops while a transfer is pending.
    always @(negedge clk)
    begin
        if (!rst_n)
            drv_valid <= 1'b0;
        else if (!drv_valid || req_taken)
        begin
            if (queued_requests.size() != 0
                && (steady || hold_left != 0 || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                cur_req   <= queued_requests.pop_front();
                drv_valid <= 1'b1;
            end
            else
                drv_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure, none during the steady phase, and once a
    // long hold-off so that the result register fills and the block has to
    // stall its request side.
    always @(negedge clk)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            sink_ready <= 1'b0;
            hold_left  <= hold_left - 1;
        end
        else if (!hold_done && requests_taken >= HOLD_AFTER)
        begin
            sink_ready <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            hold_done  <= 1'b1;
        end
        else
            sink_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Request monitor: every accepted request goes through the calculator, and a
    // completed query leaves its address in the expected store.
    always @(posedge clk)
    begin : watch_requests
        addr_request_t rq;
        addr_result_t  addr_out;
        req_taken <= rst_n && request_ch.valid && request_ch.ready;
        if (rst_n && request_ch.valid && request_ch.ready)
        begin
            rq.req_type     = request_ch.req_type;
            rq.array_id     = request_ch.array_id;
            rq.base_address = request_ch.base_address;
            rq.element_size = request_ch.element_size;
            rq.dim_count    = request_ch.dim_count;
            rq.dim_index    = request_ch.dim_index;
            rq.lower_bound  = request_ch.lower_bound;
            rq.upper_bound  = request_ch.upper_bound;
            rq.index_value  = request_ch.index_value;
            if (calc_element_address(0, rq, addr_out))
                expected_addresses.push_back(addr_out);
            requests_taken++;
        end
    end

    // Result monitor: each transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin : watch_results
        addr_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_addresses.size() == 0)
            begin
                $error("address: none expected, actual %08h", result_ch.address);
                error_count++;
            end
            else
            begin
                want = expected_addresses.pop_front();
                if (result_ch.address !== want.address)
                begin
                    $error("address: expected %08h, actual %08h", want.address,
                           result_ch.address);
                    error_count++;
                end
                if (result_ch.query_array !== want.query_array)
                begin
                    $error("query_array: expected %0d, actual %0d", want.query_array,
                           result_ch.query_array);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for too long.
    always @(posedge clk)
    begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        sub_count[0]  = '0;
        sub_count[1]  = '0;
        horner_acc[0] = '0;
        horner_acc[1] = '0;
        owner_id[0]   = '0;
        owner_id[1]   = '0;
        foreach (hdr_known[i])
            hdr_known[i] = 1'b0;
        foreach (bnd_known[i])
            bnd_known[i] = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A single dimension spanning the whole 32-bit range has
        // an extent that wraps to zero; the two extreme subscripts give offsets
        // of all ones and zero. A dimension count of zero is stored as one.
        push_header(4'd0, '0, 16'd1, 4'd0);
        push_bounds(4'd0, 3'd0, 32'h8000_0000, 32'h7fff_ffff);
        push_subscript(4'd0, 1'b1, 32'h7fff_ffff);
        push_subscript(4'd0, 1'b1, 32'h8000_0000);
        begin : spare_code
            addr_request_t rq;
            rq = noise_request();
            rq.req_type = REQ_UNUSED;
            push_request(rq);
        end

        // Largest base and element size, and a count above the limit which is
        // clamped to eight dimensions. The query carries mixed ids: only the
        // first one counts.
        push_header(4'd1, 31'h7fff_ffff, 16'hffff, 4'd15);
        push_bounds(4'd1, 3'd7, 32'hffff_fffd, 32'd4);
        push_subscript(4'd1, 1'b1, 32'd0);
        push_subscript(4'd7, 1'b1, 32'hffff_ffff);
        push_subscript(4'd15, 1'b1, 32'h8000_0000);
        push_subscript(4'd1, 1'b1, 32'h7fff_ffff);
        push_subscript(4'd0, 1'b0, '0);
        push_subscript(4'd3, 1'b0, '0);
        push_subscript(4'd1, 1'b0, '0);
        push_subscript(4'd12, 1'b1, 32'd4);

        // A header rewritten mid-query: the count drops from three to one, so
        // the next subscript finishes the query.
        push_header(4'd2, 31'h1234_5678, 16'd8, 4'd3);
        push_subscript(4'd2, 1'b0, '0);
        push_subscript(4'd9, 1'b0, '0);
        push_header(4'd2, 31'h0000_1000, 16'd4, 4'd1);
        push_subscript(4'd2, 1'b0, '0);

        queue_random(250);

        // The sender pauses here until every expected address has come back.
        wait_drained();

        // A stretch with no idling on either side.
        steady = 1'b1;
        queue_random(420);
        wait_drained();
        steady = 1'b0;

        queue_random(680);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
